/* rtl/cfq_pkg.sv */
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and constants for the coalescing frame queue
// Word formats for commands, results and stored entries, plus status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfq_pkg;

  // Default sizing
  localparam int DEFAULT_QUEUE_DEPTH   = 32;
  localparam int DEFAULT_MAX_FRAME_LEN = 96;

  // Reset value of the minimum coalescing length register
  localparam logic [6:0] MIN_LEN_RESET = 7'd10;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes
  localparam logic [2:0] STAT_APPENDED  = 3'd0;
  localparam logic [2:0] STAT_COALESCED = 3'd1;
  localparam logic [2:0] STAT_EVICTED   = 3'd2;
  localparam logic [2:0] STAT_REJECTED  = 3'd3;
  localparam logic [2:0] STAT_POPPED    = 3'd4;
  localparam logic [2:0] STAT_EMPTY     = 3'd5;

  // Command word
  typedef struct packed {
    logic        cmd;
    logic [23:0] source_key;
    logic [6:0]  frame_bytes;
    logic [15:0] payload_ref;
  } req_t;

  // Result word
  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] out_key;
    logic [6:0]  out_length;
    logic [15:0] out_ref;
    logic [5:0]  entry_count;
    logic [31:0] coalesce_total;
    logic [31:0] evict_total;
  } rsp_t;

  // One stored descriptor
  typedef struct packed {
    logic [23:0] key;
    logic [6:0]  length;
    logic [15:0] payload;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/cfq_store.sv */
// ----------------------------------------------------------------------------
// cfq_store: descriptor memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfq_store
  import cfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output entry_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [PTR_W-1:0] wr_addr,
  input  wire entry_t           wr_data
);

  entry_t mem [QUEUE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cfq_ctrl.sv */
// ----------------------------------------------------------------------------
// cfq_ctrl: queue sequencer
// Holds pointers, occupancy and counters; scans the store one entry per cycle
// from oldest to newest on a push, then appends, evicts or coalesces in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfq_ctrl
  import cfq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN,
  localparam int PTR_W        = $clog2(QUEUE_DEPTH),
  localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire req_t             req,
  output logic                  busy,
  input  wire logic [6:0]       min_len,
  output logic                  done,
  output rsp_t                  result,
  // store interface
  output logic                  mem_rd_en,
  output logic [PTR_W-1:0]      mem_rd_addr,
  input  wire entry_t           mem_rd_data,
  output logic                  mem_wr_en,
  output logic [PTR_W-1:0]      mem_wr_addr,
  output entry_t                mem_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [COUNT_W-1:0] occ, occ_next;
  logic [31:0]        coal_cnt, coal_cnt_next;
  logic [31:0]        evict_cnt, evict_cnt_next;
  req_t               req_q, req_q_next;
  logic [PTR_W-1:0]   scan_addr, scan_addr_next;
  logic [COUNT_W-1:0] scan_cnt, scan_cnt_next;
  logic               cmp_valid, cmp_valid_next;
  logic [PTR_W-1:0]   cmp_addr, cmp_addr_next;
  logic               done_next;
  rsp_t               result_next;

  req_t               cur_req;
  logic               hit;
  logic               do_append, do_coalesce, do_reject, do_empty, do_pop;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign busy = (state != S_IDLE);

  // Push data comes straight from the port when handled in the accept cycle
  assign cur_req = (state == S_IDLE) ? req : req_q;

  // Key match on the entry read last cycle
  assign hit = (mem_rd_data.key == req_q.source_key) && (mem_rd_data.length >= min_len);

  // Sequencing
  always_comb begin
    state_next     = state;
    req_q_next     = req_q;
    scan_addr_next = scan_addr;
    scan_cnt_next  = scan_cnt;
    cmp_valid_next = 1'b0;
    cmp_addr_next  = cmp_addr;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = rd_ptr;
    do_append      = 1'b0;
    do_coalesce    = 1'b0;
    do_reject      = 1'b0;
    do_empty       = 1'b0;
    do_pop         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q_next = req;
          if (req.cmd == CMD_POP) begin
            if (occ == '0) begin
              do_empty = 1'b1;
            end else begin
              mem_rd_en  = 1'b1;
              state_next = S_POP;
            end
          end else if (req.frame_bytes == 7'd0 ||
                       req.frame_bytes > 7'(MAX_FRAME_LEN)) begin
            do_reject = 1'b1;
          end else if (occ == '0 || req.frame_bytes < min_len) begin
            // nothing can match: append at once
            do_append = 1'b1;
          end else begin
            scan_addr_next = rd_ptr;
            scan_cnt_next  = '0;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_valid && hit) begin
          do_coalesce = 1'b1;
          state_next  = S_IDLE;
        end else if (!cmp_valid && scan_cnt == occ) begin
          do_append  = 1'b1;
          state_next = S_IDLE;
        end else if (scan_cnt != occ) begin
          // issue the next read, compare it next cycle
          mem_rd_en      = 1'b1;
          mem_rd_addr    = scan_addr;
          cmp_valid_next = 1'b1;
          cmp_addr_next  = scan_addr;
          scan_addr_next = advance(scan_addr);
          scan_cnt_next  = scan_cnt + COUNT_W'(1);
        end
      end
      S_POP: begin
        do_pop     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Queue update and result word
  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    occ_next       = occ;
    coal_cnt_next  = coal_cnt;
    evict_cnt_next = evict_cnt;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = wr_ptr;
    mem_wr_data    = '{key: cur_req.source_key, length: cur_req.frame_bytes,
                       payload: cur_req.payload_ref};
    result_next    = result;
    result_next.out_key    = '0;
    result_next.out_length = '0;
    result_next.out_ref    = '0;
    result_next.status     = STAT_REJECTED;

    if (do_empty) begin
      result_next.status = STAT_EMPTY;
    end

    if (do_coalesce) begin
      mem_wr_en          = 1'b1;
      mem_wr_addr        = cmp_addr;
      coal_cnt_next      = coal_cnt + 32'd1;
      result_next.status = STAT_COALESCED;
    end

    if (do_append) begin
      mem_wr_en   = 1'b1;
      wr_ptr_next = advance(wr_ptr);
      if (occ == COUNT_W'(QUEUE_DEPTH)) begin
        // full: drop the oldest entry to make room
        rd_ptr_next        = advance(rd_ptr);
        evict_cnt_next     = evict_cnt + 32'd1;
        result_next.status = STAT_EVICTED;
      end else begin
        occ_next           = occ + COUNT_W'(1);
        result_next.status = STAT_APPENDED;
      end
    end

    if (do_pop) begin
      rd_ptr_next            = advance(rd_ptr);
      occ_next               = occ - COUNT_W'(1);
      result_next.status     = STAT_POPPED;
      result_next.out_key    = mem_rd_data.key;
      result_next.out_length = mem_rd_data.length;
      result_next.out_ref    = mem_rd_data.payload;
    end

    result_next.entry_count    = 6'(occ_next);
    result_next.coalesce_total = coal_cnt_next;
    result_next.evict_total    = evict_cnt_next;
    done_next = do_empty | do_reject | do_append | do_coalesce | do_pop;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      occ       <= '0;
      coal_cnt  <= '0;
      evict_cnt <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      occ       <= occ_next;
      coal_cnt  <= coal_cnt_next;
      evict_cnt <= evict_cnt_next;
      cmp_valid <= cmp_valid_next;
      done      <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_q     <= req_q_next;
    scan_addr <= scan_addr_next;
    scan_cnt  <= scan_cnt_next;
    cmp_addr  <= cmp_addr_next;
    result    <= result_next;
  end

endmodule

`default_nettype wire

/* rtl/coalescing_frame_queue.sv */
// ----------------------------------------------------------------------------
// coalescing_frame_queue: FIFO of frame descriptors with source coalescing
// A push overwrites the oldest entry with the same source key (when both
// lengths reach the minimum), else appends, evicting the oldest when full.
//
//   channel   direction  signals                     handshake
//   command   in         start, busy, req            start & !busy
//   result    out        done, result                done, one cycle
//   config    in         cfg_wr_en, cfg_wr_data      cfg_wr_en
//
// Pop: the entry is read in the accept cycle and returned from S_POP. Reject,
// empty pop, or a push that cannot match: answered from the accept cycle.
// Scanned push: one stored key read per cycle from the store's single read port.
// Reset clears pointers, occupancy and counters; memory contents are not
// cleared. done is never held off; busy stays high until the result is out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coalescing_frame_queue
  import cfq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire req_t       req,
  output logic            busy,
  output logic            done,
  output rsp_t            result,
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [6:0]       min_len;
  logic             mem_rd_en, mem_wr_en;
  logic [PTR_W-1:0] mem_rd_addr, mem_wr_addr;
  entry_t           mem_rd_data, mem_wr_data;

  // Minimum coalescing length register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len <= cfg_wr_data;
    end
  end

  cfq_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .busy        (busy),
    .min_len     (min_len),
    .done        (done),
    .result      (result),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  cfq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Bad push length is answered as rejected in the next cycle
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.cmd == CMD_PUSH &&
     (req.frame_bytes == 7'd0 || req.frame_bytes > 7'(MAX_FRAME_LEN)))
    |=> (done && result.status == STAT_REJECTED))
    else $error("bad-length push not rejected");

  // Only pushes with a nonzero length are stored, so a pop never returns zero
  a_pop_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_POPPED) |-> (result.out_length != 7'd0))
    else $error("popped entry with zero length");

  // Entry fields are zero on every status but popped
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_POPPED) |->
    (result.out_key == '0 && result.out_length == '0 && result.out_ref == '0))
    else $error("entry fields not cleared");

  // A multi-cycle command never answers in its first busy cycle
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy)) |-> !done)
    else $error("result while sequence just started");

endmodule

`default_nettype wire
